// File: design/qrm_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: shared package
// Transfer types, lane layout and saturation helper for the conversion unit.
// ----------------------------------------------------------------------------
package qrm_pkg;

   localparam int LANES     = 9;
   localparam int PROD_W    = 32;
   localparam int MAG_W     = 32;
   localparam int DEN_W     = 33;
   localparam int QUO_W     = 17;
   localparam int DIV_STEPS = 17;
   localparam int UQ_W      = 20;
   localparam int VAL_W     = 23;

   localparam logic signed [VAL_W-1:0] Q_ONE   = 23'sd16384;
   localparam logic signed [VAL_W-1:0] SAT_MAX = 23'sd32767;
   localparam logic signed [VAL_W-1:0] SAT_MIN = -23'sd32768;

   // Lanes follow the result field order; diagonal lanes subtract from one.
   localparam logic [LANES-1:0] IS_DIAG = 9'b100010001;

   typedef struct packed {
      logic signed [15:0] in_w;
      logic signed [15:0] in_x;
      logic signed [15:0] in_y;
      logic signed [15:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] e00;
      logic signed [15:0] e10;
      logic signed [15:0] e20;
      logic signed [15:0] e01;
      logic signed [15:0] e11;
      logic signed [15:0] e21;
      logic signed [15:0] e02;
      logic signed [15:0] e12;
      logic signed [15:0] e22;
   } rsp_type;

   // Numerator magnitudes, signs and the shared divisor leaving the front end.
   typedef struct packed {
      logic [LANES-1:0][MAG_W-1:0] mag;
      logic [LANES-1:0]            neg;
      logic [DEN_W-1:0]            den;
      logic                        zero;
      logic                        unit;
   } front_type;

   function automatic logic signed [15:0] sat16(input logic signed [VAL_W-1:0] v);
      logic signed [15:0] r;
      if (v > SAT_MAX) begin
         r = 16'sh7fff;
      end else if (v < SAT_MIN) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// File: design/quaternion_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix unit
// Throughput: one quaternion per cycle while results are taken; the 17-stage divider is fully pipelined.
// Reset (synchronous, active high) empties the pipeline and clears assume_unit.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_unit import qrm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   // Pipeline layout: input register, products, numerators, 17 divide steps
   // and the output register.
   localparam int LAT      = 4 + DIV_STEPS;
   localparam int DIV_LAST = 3 + DIV_STEPS - 1;

   // Per-lane information that rides alongside the divider stages.
   typedef struct packed {
      logic [LANES-1:0][UQ_W-1:0] uq;
      logic [LANES-1:0]           neg;
      logic                       zero;
      logic                       unit;
   } side_type;

   logic                        assume_unit_ff;
   logic [LAT-1:0]              valid_ff;
   logic                        advance;
   req_type                     quat_ff;
   front_type                   front;
   logic [LANES-1:0][QUO_W-1:0] quo;
   side_type                    side_ff [DIV_STEPS];
   side_type                    side_in;
   rsp_type                     rsp_ff, rsp_in;

   // The whole pipeline moves unless a finished result waits on the consumer.
   // Bubbles move too, so an item can follow in the very next cycle.
   assign advance   = !(valid_ff[LAT-1] && !rsp_ready);
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         assume_unit_ff <= 1'b0;
         valid_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            assume_unit_ff <= csr_wr_data;
         end
         if (advance) begin
            valid_ff <= {valid_ff[LAT-2:0], req_valid};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quat_ff    <= req_data;
         side_ff[0] <= side_in;
         for (int k = 1; k < DIV_STEPS; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   qrm_front u_front (
      .clock   (clock),
      .advance (advance),
      .quat    (quat_ff),
      .unit    (assume_unit_ff),
      .front   (front)
   );

   qrm_divider u_divider (
      .clock   (clock),
      .advance (advance),
      .mag     (front.mag),
      .den     (front.den),
      .quo     (quo)
   );

   // In unit mode the divisor is 2^28, so the rounded quotient is a shift:
   // round(mag / 2^13) = ((mag >> 12) + 1) >> 1.
   always_comb begin
      logic [UQ_W:0] t;
      for (int l = 0; l < LANES; l++) begin
         t             = {1'b0, front.mag[l][MAG_W-1:12]} + (UQ_W+1)'(1);
         side_in.uq[l] = t[UQ_W:1];
      end
      side_in.neg  = front.neg;
      side_in.zero = front.zero;
      side_in.unit = front.unit;
   end

   // The divider yields floor(2 * mag * 2^15 / N); adding one and halving
   // rounds to nearest with ties away from zero. A zero norm gives zero.
   always_comb begin
      side_type              s;
      logic [QUO_W:0]        qr;
      logic [UQ_W-1:0]       q;
      logic signed [VAL_W-1:0] v;
      logic signed [15:0]    e [LANES];
      s = side_ff[DIV_STEPS-1];
      for (int l = 0; l < LANES; l++) begin
         qr = {1'b0, quo[l]} + (QUO_W+1)'(1);
         if (s.unit) begin
            q = s.uq[l];
         end else if (s.zero) begin
            q = '0;
         end else begin
            q = UQ_W'(qr[QUO_W:1]);
         end
         v = s.neg[l] ? -$signed({3'b000, q}) : $signed({3'b000, q});
         if (IS_DIAG[l]) begin
            v = Q_ONE - v;
         end
         e[l] = sat16(v);
      end
      rsp_in.e00 = e[0];
      rsp_in.e10 = e[1];
      rsp_in.e20 = e[2];
      rsp_in.e01 = e[3];
      rsp_in.e11 = e[4];
      rsp_in.e21 = e[5];
      rsp_in.e02 = e[6];
      rsp_in.e12 = e[7];
      rsp_in.e22 = e[8];
   end

   // In general mode every quotient is at most one, so the divider output
   // never passes 2^16.
   logic quo_in_range;
   always_comb begin
      quo_in_range = 1'b1;
      for (int l = 0; l < LANES; l++) begin
         if (quo[l][QUO_W-1] && (quo[l][QUO_W-2:0] != '0)) begin
            quo_in_range = 1'b0;
         end
      end
   end

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !valid_ff[0])
      else $error("pipeline not empty after reset");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_LAST] && !side_ff[DIV_STEPS-1].unit && !side_ff[DIV_STEPS-1].zero
      |-> quo_in_range)
      else $error("divider quotient exceeds one");

   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      advance && valid_ff[DIV_LAST] && side_ff[DIV_STEPS-1].zero
      && !side_ff[DIV_STEPS-1].unit
      |=> rsp_data.e00 == 16'sd16384 && rsp_data.e11 == 16'sd16384
          && rsp_data.e22 == 16'sd16384 && rsp_data.e10 == 16'sd0
          && rsp_data.e01 == 16'sd0 && rsp_data.e21 == 16'sd0)
      else $error("zero quaternion did not give identity");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff) && $stable(side_ff[DIV_STEPS-1]))
      else $error("pipeline moved during a stall");

endmodule

// File: design/qrm_front.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: product and numerator stages
// Registers the ten component products, then the nine numerators and the norm.
// ----------------------------------------------------------------------------
module qrm_front import qrm_pkg::*; (
   input  logic      clock,
   input  logic      advance,
   input  req_type   quat,
   input  logic      unit,
   output front_type front
);

   logic signed [PROD_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [PROD_W-1:0] wx_ff, wy_ff, wz_ff;
   logic                     unit_ff;
   front_type                front_ff, front_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         ww_ff   <= PROD_W'(quat.in_w) * PROD_W'(quat.in_w);
         xx_ff   <= PROD_W'(quat.in_x) * PROD_W'(quat.in_x);
         yy_ff   <= PROD_W'(quat.in_y) * PROD_W'(quat.in_y);
         zz_ff   <= PROD_W'(quat.in_z) * PROD_W'(quat.in_z);
         xy_ff   <= PROD_W'(quat.in_x) * PROD_W'(quat.in_y);
         xz_ff   <= PROD_W'(quat.in_x) * PROD_W'(quat.in_z);
         yz_ff   <= PROD_W'(quat.in_y) * PROD_W'(quat.in_z);
         wx_ff   <= PROD_W'(quat.in_w) * PROD_W'(quat.in_x);
         wy_ff   <= PROD_W'(quat.in_w) * PROD_W'(quat.in_y);
         wz_ff   <= PROD_W'(quat.in_w) * PROD_W'(quat.in_z);
         unit_ff <= unit;
         front_ff <= front_in;
      end
   end

   function automatic logic signed [DEN_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      return {p[PROD_W-1], p};
   endfunction

   always_comb begin
      logic signed [DEN_W-1:0] num [LANES];
      num[0] = ext(yy_ff) + ext(zz_ff);
      num[1] = ext(xy_ff) - ext(wz_ff);
      num[2] = ext(xz_ff) + ext(wy_ff);
      num[3] = ext(xy_ff) + ext(wz_ff);
      num[4] = ext(xx_ff) + ext(zz_ff);
      num[5] = ext(yz_ff) - ext(wx_ff);
      num[6] = ext(xz_ff) - ext(wy_ff);
      num[7] = ext(yz_ff) + ext(wx_ff);
      num[8] = ext(xx_ff) + ext(yy_ff);
      for (int l = 0; l < LANES; l++) begin
         front_in.neg[l] = num[l][DEN_W-1];
         front_in.mag[l] = num[l][DEN_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      end
      // Squares are never negative, so the norm is a plain unsigned sum.
      front_in.den  = {1'b0, ww_ff} + {1'b0, xx_ff} + {1'b0, yy_ff} + {1'b0, zz_ff};
      front_in.zero = (front_in.den == '0);
      front_in.unit = unit_ff;
   end

   assign front = front_ff;

endmodule

// File: design/qrm_divider.sv
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix: pipelined divider
// Restoring division of nine numerators by the shared norm, one bit a stage.
// ----------------------------------------------------------------------------
module qrm_divider import qrm_pkg::*; (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [LANES-1:0][MAG_W-1:0] mag,
   input  logic [DEN_W-1:0]            den,
   output logic [LANES-1:0][QUO_W-1:0] quo
);

   logic [DEN_W-1:0]            den_ff [DIV_STEPS];
   logic [LANES-1:0][DEN_W-1:0] rem_ff [DIV_STEPS];
   logic [LANES-1:0][DEN_W-1:0] rem_in [DIV_STEPS];
   logic [LANES-1:0][QUO_W-1:0] quo_ff [DIV_STEPS];
   logic [LANES-1:0][QUO_W-1:0] quo_in [DIV_STEPS];

   // First step: the quotient's top bit is whether the numerator reaches the norm.
   always_comb begin
      logic ge;
      for (int l = 0; l < LANES; l++) begin
         ge = ({1'b0, mag[l]} >= den);
         rem_in[0][l] = ge ? ({1'b0, mag[l]} - den) : {1'b0, mag[l]};
         quo_in[0][l] = {{(QUO_W-1){1'b0}}, ge};
      end
   end

   for (genvar k = 1; k < DIV_STEPS; k++) begin : g_step
      always_comb begin
         logic [DEN_W:0] shifted;
         logic [DEN_W:0] diff;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            shifted = {rem_ff[k-1][l], 1'b0};
            ge      = (shifted >= {1'b0, den_ff[k-1]});
            diff    = shifted - {1'b0, den_ff[k-1]};
            rem_in[k][l] = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_in[k][l] = {quo_ff[k-1][l][QUO_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff[0] <= den;
         for (int k = 1; k < DIV_STEPS; k++) begin
            den_ff[k] <= den_ff[k-1];
         end
         for (int k = 0; k < DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_STEPS-1];

endmodule
